FILE: hdl/smo_pkg.sv
// Shared types, constants and helper functions for the SMO trainer.
`timescale 1ns / 1ps
package smo_pkg;

	localparam int DEF_MAX_SAMPLES = 64;
	localparam int DEF_KERNEL_BITS = 16;
	localparam int DEF_FRAC_BITS   = 16;

	localparam int CMD_W     = 3;
	localparam int IDX_W     = 6;
	localparam int LV_W      = 16;
	localparam int RES_W     = 48;
	localparam int KIND_W    = 2;
	localparam int PEN_W     = 16;
	localparam int TOL_W     = 16;
	localparam int CNT_W     = 7;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int DW        = 64;
	localparam int DIV_CNT_W = 6;

	localparam logic [CNT_W-1:0] ACTIVE_RST = 7'd64;

	localparam logic signed [DW-1:0] BIAS_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [DW-1:0] BIAS_MIN = 64'shFFFF_8000_0000_0000;

	typedef enum logic [CMD_W-1:0] {
		OP_LOAD_K = 3'd0,
		OP_LOAD_L = 3'd1,
		OP_LOAD_P = 3'd2,
		OP_RUN    = 3'd3,
		OP_READ   = 3'd4
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PENALTY = 2'd0,
		CFG_TOL     = 2'd1,
		CFG_ACTIVE  = 2'd2
	} cfg_idx_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ALPHA = 2'd0,
		KIND_BIAS  = 2'd1,
		KIND_UPD   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		MUL_ERR,
		MUL_TI_KII,
		MUL_TJ_KIJ,
		MUL_TI_KIJ,
		MUL_TJ_KJJ
	} mul_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RD, ST_EMIT, ST_PINIT,
		ST_ERUN, ST_EDR1, ST_EDR2, ST_EFIN,
		ST_KKT, ST_JCHK, ST_ECHK, ST_LHCHK, ST_ETA,
		ST_DIVGO, ST_DIVW, ST_CLIP, ST_DACHK,
		ST_M1, ST_M2, ST_M3, ST_M4, ST_M5,
		ST_BIAS, ST_WAJ, ST_NEXT, ST_DONE
	} state_t;

	typedef struct packed {
		logic     load;
		logic     rd_cap;
		logic     emit;
		logic     pass_init;
		logic     err_start;
		logic     sel_j;
		logic     err_issue;
		logic     err_fin;
		logic     part_rd;
		logic     j_latch;
		logic     bnd_latch;
		logic     kij_rd;
		logic     eta_latch;
		logic     div_start;
		logic     clip;
		logic     da_latch;
		mul_sel_t mul;
		logic     b1_init;
		logic     b1_sub;
		logic     b2_init;
		logic     b2_sub;
		logic     bias_upd;
		logic     aj_wr;
		logic     i_inc;
		logic     done_cap;
	} smo_cmd_t;

	typedef struct packed {
		logic rd_ok;
		logic out_free;
		logic n_zero;
		logic k_last;
		logic i_last;
		logic x_is_j;
		logic viol;
		logic jbad;
		logic e_close;
		logic lh_close;
		logic eta_nonneg;
		logic div_done;
		logic da_small;
	} smo_stat_t;

	function automatic logic [DW-1:0] abs64(input logic signed [DW-1:0] v);
		abs64 = v[DW-1] ? (~v + 64'd1) : v;
	endfunction

	function automatic logic signed [DW-1:0] smax64(input logic signed [DW-1:0] a,
			input logic signed [DW-1:0] b);
		smax64 = (a > b) ? a : b;
	endfunction

	function automatic logic signed [DW-1:0] smin64(input logic signed [DW-1:0] a,
			input logic signed [DW-1:0] b);
		smin64 = (a < b) ? a : b;
	endfunction

endpackage

FILE: hdl/smo_in_if.sv
// Command channel interface of the SMO trainer.
`timescale 1ns / 1ps
interface smo_in_if import smo_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        cmd;
	logic [IDX_W-1:0]        row_index;
	logic [IDX_W-1:0]        col_index;
	logic signed [LV_W-1:0]  load_value;

	modport source(output valid, cmd, row_index, col_index, load_value, input ready);
	modport sink(input valid, cmd, row_index, col_index, load_value, output ready);
endinterface

FILE: hdl/smo_out_if.sv
// Result channel interface of the SMO trainer.
`timescale 1ns / 1ps
interface smo_out_if import smo_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [RES_W-1:0] result_value;
	logic [KIND_W-1:0]       result_kind;

	modport source(output valid, result_value, result_kind, input ready);
	modport sink(input valid, result_value, result_kind, output ready);
endinterface

FILE: hdl/smo_div.sv
// Radix-2 restoring divider, 64-bit unsigned, one quotient bit per cycle.
`timescale 1ns / 1ps
module smo_div import smo_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic [DW-1:0] quotient,
	output logic          done
);

	logic [DW-1:0]        rem_q;
	logic [DW-1:0]        quo_q;
	logic [DW-1:0]        den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DW:0]          trial;
	logic                 fits;

	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == '1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

FILE: hdl/smo_dp.sv
// Datapath: stores, config registers, error accumulator, pair update and bias logic.
`timescale 1ns / 1ps
module smo_dp import smo_pkg::*; #(
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
	parameter int KERNEL_BITS = DEF_KERNEL_BITS,
	parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic [CMD_W-1:0]        req_cmd,
	input  logic [IDX_W-1:0]        req_row,
	input  logic [IDX_W-1:0]        req_col,
	input  logic signed [LV_W-1:0]  req_value,
	input  smo_cmd_t                cmd,
	output smo_stat_t               st,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic signed [RES_W-1:0] out_value,
	output logic [KIND_W-1:0]       out_kind
);

	localparam int AW   = $clog2(MAX_SAMPLES);
	localparam int NW   = $clog2(MAX_SAMPLES + 1);
	localparam int AL_W = PEN_W + FRAC_BITS;
	localparam int MB   = AL_W + 2;
	localparam int KB   = KERNEL_BITS;
	localparam int KD   = 1 << (2 * AW);
	localparam logic signed [DW-1:0] ONE = 64'sd1 << FRAC_BITS;

	// configuration
	logic [PEN_W-1:0] pen_q;
	logic [TOL_W-1:0] tol_q;
	logic [CNT_W-1:0] active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_q    <= PEN_W'(1);
			tol_q    <= TOL_W'(1);
			active_q <= ACTIVE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PENALTY: pen_q    <= cfg_data[PEN_W-1:0];
				CFG_TOL:     tol_q    <= cfg_data[TOL_W-1:0];
				CFG_ACTIVE:  active_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	logic [NW-1:0]          n_w;
	logic signed [DW-1:0]   cq64;
	logic signed [DW-1:0]   tol64;

	assign n_w   = (32'(active_q) > MAX_SAMPLES) ? NW'(MAX_SAMPLES) : NW'(active_q);
	assign cq64  = signed'(64'(pen_q) << FRAC_BITS);
	assign tol64 = signed'(64'(tol_q));

	// input decode
	logic          row_ok;
	logic          col_ok;
	logic [AW-1:0] row_a;
	logic [AW-1:0] col_a;

	assign row_ok = 32'(req_row) < MAX_SAMPLES;
	assign col_ok = 32'(req_col) < MAX_SAMPLES;
	assign row_a  = AW'(req_row);
	assign col_a  = AW'(req_col);

	// indices and sequencing
	logic [AW-1:0] i_q;
	logic [AW-1:0] j_q;
	logic [AW-1:0] k_q;
	logic          x_sel_q;
	logic [AW-1:0] x_a;
	logic [NW-1:0] count_q;

	assign x_a = x_sel_q ? j_q : i_q;

	// stores
	logic signed [KB-1:0] kern_mem [KD];
	logic                 label_mem [MAX_SAMPLES];
	logic [IDX_W-1:0]     part_mem [MAX_SAMPLES];
	logic [AL_W-1:0]      alpha_mem [MAX_SAMPLES];
	logic                 alpha_vld [MAX_SAMPLES];

	logic signed [KB-1:0] kern_rd;
	logic                 label_rd;
	logic [IDX_W-1:0]     part_rd;
	logic [AL_W-1:0]      alpha_rd;
	logic                 alpha_vrd;
	logic [AL_W-1:0]      alpha_eff;

	logic                 kern_we;
	logic                 label_we;
	logic                 part_we;
	logic [2*AW-1:0]      kern_ra;
	logic [AW-1:0]        alpha_ra;
	logic                 alpha_we;
	logic [AW-1:0]        alpha_wa;
	logic [AL_W-1:0]      alpha_wd;

	logic signed [DW-1:0] ai_q;
	logic signed [DW-1:0] aj_q;

	assign kern_we  = cmd.load && (req_cmd == OP_LOAD_K) && row_ok && col_ok;
	assign label_we = cmd.load && (req_cmd == OP_LOAD_L) && row_ok;
	assign part_we  = cmd.load && (req_cmd == OP_LOAD_P) && row_ok;
	assign kern_ra  = cmd.kij_rd ? {i_q, j_q} : {x_a, k_q};
	assign alpha_ra = cmd.load ? row_a : k_q;
	assign alpha_we = cmd.bias_upd || cmd.aj_wr;
	assign alpha_wa = cmd.aj_wr ? j_q : i_q;
	assign alpha_wd = cmd.aj_wr ? AL_W'(aj_q) : AL_W'(ai_q);
	assign alpha_eff = alpha_vrd ? alpha_rd : '0;

	always_ff @(posedge clk) begin
		if (kern_we)
			kern_mem[{row_a, col_a}] <= KB'(req_value);
		kern_rd <= kern_mem[kern_ra];
	end

	always_ff @(posedge clk) begin
		if (label_we)
			label_mem[row_a] <= req_value[LV_W-1];
		label_rd <= label_mem[k_q];
	end

	always_ff @(posedge clk) begin
		if (part_we)
			part_mem[row_a] <= req_col;
		if (cmd.part_rd)
			part_rd <= part_mem[i_q];
	end

	always_ff @(posedge clk) begin
		if (alpha_we)
			alpha_mem[alpha_wa] <= alpha_wd;
		alpha_rd  <= alpha_mem[alpha_ra];
		alpha_vrd <= alpha_vld[alpha_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < MAX_SAMPLES; e++)
				alpha_vld[e] <= 1'b0;
		end else if (alpha_we) begin
			alpha_vld[alpha_wa] <= 1'b1;
		end
	end

	// control registers of the pass
	logic v_s1;
	logic v_s2;
	logic rd_bias_q;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q         <= '0;
			k_q         <= '0;
			j_q         <= '0;
			x_sel_q     <= 1'b0;
			count_q     <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			rd_bias_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= cmd.err_issue;
			v_s2 <= v_s1;
			if (cmd.pass_init) begin
				i_q     <= '0;
				count_q <= '0;
			end else if (cmd.i_inc) begin
				i_q <= i_q + 1'b1;
			end
			if (cmd.aj_wr)
				count_q <= count_q + 1'b1;
			if (cmd.err_start) begin
				k_q     <= '0;
				x_sel_q <= cmd.sel_j;
			end else if (cmd.err_issue) begin
				k_q <= k_q + 1'b1;
			end
			if (cmd.j_latch)
				j_q <= AW'(part_rd);
			if (cmd.load)
				rd_bias_q <= (req_col == IDX_W'(1));
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// error pipeline and shared multiplier
	logic [AW-1:0]         k_s1;
	logic                  l_s2;
	logic signed [DW-1:0]  prod_s2;
	logic signed [KB-1:0]  ma;
	logic signed [MB-1:0]  mb;
	logic signed [KB+MB-1:0] mfull;
	logic signed [KB-1:0]  kii_q;
	logic signed [KB-1:0]  kjj_q;
	logic signed [KB-1:0]  kij_q;
	logic signed [MB-1:0]  ti_q;
	logic signed [MB-1:0]  tj_q;

	always_comb begin
		case (cmd.mul)
			MUL_ERR: begin
				ma = kern_rd;
				mb = signed'({2'b00, alpha_eff});
			end
			MUL_TI_KII: begin
				ma = kii_q;
				mb = ti_q;
			end
			MUL_TJ_KIJ: begin
				ma = kij_q;
				mb = tj_q;
			end
			MUL_TI_KIJ: begin
				ma = kij_q;
				mb = ti_q;
			end
			MUL_TJ_KJJ: begin
				ma = kjj_q;
				mb = tj_q;
			end
			default: begin
				ma = kern_rd;
				mb = signed'({2'b00, alpha_eff});
			end
		endcase
	end

	assign mfull = ma * mb;

	logic signed [RES_W-1:0] bias_q;
	logic signed [DW-1:0]    bias64;
	logic signed [DW-1:0]    acc_q;
	logic signed [DW-1:0]    ei_q;
	logic signed [DW-1:0]    ej_q;
	logic [AL_W-1:0]         aio_q;
	logic [AL_W-1:0]         ajo_q;
	logic                    li_q;
	logic                    lj_q;

	assign bias64 = DW'(bias_q);

	always_ff @(posedge clk) begin
		k_s1    <= k_q;
		l_s2    <= label_rd;
		prod_s2 <= DW'(mfull);
		if (v_s1 && (k_s1 == x_a)) begin
			if (x_sel_q) begin
				ajo_q <= alpha_eff;
				lj_q  <= label_rd;
				kjj_q <= kern_rd;
			end else begin
				aio_q <= alpha_eff;
				li_q  <= label_rd;
				kii_q <= kern_rd;
			end
		end
		if (cmd.err_start)
			acc_q <= bias64;
		else if (v_s2)
			acc_q <= l_s2 ? acc_q - prod_s2 : acc_q + prod_s2;
		if (cmd.err_fin) begin
			if (x_sel_q)
				ej_q <= lj_q ? acc_q + ONE : acc_q - ONE;
			else
				ei_q <= li_q ? acc_q + ONE : acc_q - ONE;
		end
	end

	// pair update
	logic signed [DW-1:0] aio64;
	logic signed [DW-1:0] ajo64;
	logic signed [DW-1:0] ye;
	logic signed [DW-1:0] diff_e;
	logic signed [DW-1:0] diff_a;
	logic signed [DW-1:0] sum_a;
	logic signed [DW-1:0] lo_c;
	logic signed [DW-1:0] hi_c;
	logic signed [DW-1:0] lo_q;
	logic signed [DW-1:0] hi_q;
	logic signed [DW-1:0] eta_c;
	logic signed [DW-1:0] eta_q;
	logic                 div_neg_q;
	logic [DW-1:0]        quo;
	logic                 div_done;
	logic signed [DW-1:0] step;
	logic signed [DW-1:0] ajn;
	logic signed [DW-1:0] daj;
	logic signed [DW-1:0] dai;
	logic                 same;

	assign aio64  = signed'(DW'(aio_q));
	assign ajo64  = signed'(DW'(ajo_q));
	assign same   = li_q == lj_q;
	assign ye     = li_q ? -ei_q : ei_q;
	assign diff_e = ei_q - ej_q;
	assign diff_a = ajo64 - aio64;
	assign sum_a  = ajo64 + aio64;
	assign lo_c   = same ? smax64('0, sum_a - cq64) : smax64('0, diff_a);
	assign hi_c   = same ? smin64(cq64, sum_a) : smin64(cq64, cq64 + diff_a);
	assign eta_c  = (DW'(kern_rd) <<< 1) - DW'(kii_q) - DW'(kjj_q);
	assign step   = div_neg_q ? -signed'(quo) : signed'(quo);
	assign ajn    = lj_q ? ajo64 + step : ajo64 - step;
	assign daj    = aj_q - ajo64;
	assign dai    = same ? -daj : daj;

	smo_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (abs64(diff_e)),
		.divisor  (abs64(eta_q)),
		.quotient (quo),
		.done     (div_done)
	);

	logic signed [DW-1:0] b1_q;
	logic signed [DW-1:0] b2_q;
	logic signed [DW-1:0] bsum;
	logic signed [DW-1:0] nb;
	logic signed [DW-1:0] nb_sat;

	assign bsum = b1_q + b2_q;

	always_comb begin
		if (ai_q > 0 && ai_q < cq64)
			nb = b1_q;
		else if (aj_q > 0 && aj_q < cq64)
			nb = b2_q;
		else
			nb = bsum >>> 1;
		if (nb > BIAS_MAX)
			nb_sat = BIAS_MAX;
		else if (nb < BIAS_MIN)
			nb_sat = BIAS_MIN;
		else
			nb_sat = nb;
	end

	always_ff @(posedge clk) begin
		if (cmd.bnd_latch) begin
			lo_q <= lo_c;
			hi_q <= hi_c;
		end
		if (cmd.eta_latch) begin
			eta_q <= eta_c;
			kij_q <= kern_rd;
		end
		if (cmd.div_start)
			div_neg_q <= diff_e[DW-1] != eta_q[DW-1];
		if (cmd.clip)
			aj_q <= smax64(lo_q, smin64(hi_q, ajn));
		if (cmd.da_latch) begin
			ai_q <= same ? aio64 - daj : aio64 + daj;
			ti_q <= MB'(li_q ? -dai : dai);
			tj_q <= MB'(lj_q ? -daj : daj);
		end
		if (cmd.b1_init)
			b1_q <= bias64 - ei_q - prod_s2;
		else if (cmd.b1_sub)
			b1_q <= b1_q - prod_s2;
		if (cmd.b2_init)
			b2_q <= bias64 - ej_q - prod_s2;
		else if (cmd.b2_sub)
			b2_q <= b2_q - prod_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bias_q <= '0;
		else if (cmd.bias_upd)
			bias_q <= RES_W'(nb_sat);
	end

	// result staging and output register
	logic signed [RES_W-1:0] pend_val_q;
	logic [KIND_W-1:0]       pend_kind_q;
	logic signed [RES_W-1:0] out_val_q;
	logic [KIND_W-1:0]       out_kind_q;

	always_ff @(posedge clk) begin
		if (cmd.rd_cap) begin
			pend_val_q  <= rd_bias_q ? bias_q : signed'(RES_W'(alpha_eff));
			pend_kind_q <= rd_bias_q ? KIND_BIAS : KIND_ALPHA;
		end else if (cmd.done_cap) begin
			pend_val_q  <= signed'(RES_W'(count_q));
			pend_kind_q <= KIND_UPD;
		end
		if (cmd.emit) begin
			out_val_q  <= pend_val_q;
			out_kind_q <= pend_kind_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_val_q;
	assign out_kind  = out_kind_q;

	// status
	assign st.rd_ok      = ((req_col == '0) && row_ok) || (req_col == IDX_W'(1));
	assign st.out_free   = !out_valid_q || out_ready;
	assign st.n_zero     = n_w == '0;
	assign st.k_last     = (NW'(k_q) + NW'(1)) == n_w;
	assign st.i_last     = (NW'(i_q) + NW'(1)) == n_w;
	assign st.x_is_j     = x_sel_q;
	assign st.viol       = ((ye < -tol64) && (aio64 < cq64)) || ((ye > tol64) && (aio64 > 0));
	assign st.jbad       = (32'(part_rd) >= 32'(n_w)) || (AW'(part_rd) == i_q);
	assign st.e_close    = abs64(diff_e) < DW'(tol_q);
	assign st.lh_close   = abs64(lo_q - hi_q) < DW'(tol_q);
	assign st.eta_nonneg = !eta_c[DW-1];
	assign st.div_done   = div_done;
	assign st.da_small   = abs64(daj) < DW'(tol_q);

endmodule

FILE: hdl/smo_ctrl.sv
// Controller state machine sequencing loads, reads and SMO passes.
`timescale 1ns / 1ps
module smo_ctrl import smo_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [CMD_W-1:0] in_cmd,
	input  smo_stat_t        st,
	output logic             in_ready,
	output smo_cmd_t         cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_cmd == OP_RUN)
						state_d = ST_PINIT;
					else if (in_cmd == OP_READ && st.rd_ok)
						state_d = ST_RD;
				end
			end
			ST_RD:    state_d = ST_EMIT;
			ST_EMIT:  if (st.out_free) state_d = ST_IDLE;
			ST_PINIT: state_d = st.n_zero ? ST_DONE : ST_ERUN;
			ST_ERUN:  if (st.k_last) state_d = ST_EDR1;
			ST_EDR1:  state_d = ST_EDR2;
			ST_EDR2:  state_d = ST_EFIN;
			ST_EFIN:  state_d = st.x_is_j ? ST_ECHK : ST_KKT;
			ST_KKT:   state_d = st.viol ? ST_JCHK : ST_NEXT;
			ST_JCHK:  state_d = st.jbad ? ST_NEXT : ST_ERUN;
			ST_ECHK:  state_d = st.e_close ? ST_NEXT : ST_LHCHK;
			ST_LHCHK: state_d = st.lh_close ? ST_NEXT : ST_ETA;
			ST_ETA:   state_d = st.eta_nonneg ? ST_NEXT : ST_DIVGO;
			ST_DIVGO: state_d = ST_DIVW;
			ST_DIVW:  if (st.div_done) state_d = ST_CLIP;
			ST_CLIP:  state_d = ST_DACHK;
			ST_DACHK: state_d = st.da_small ? ST_NEXT : ST_M1;
			ST_M1:    state_d = ST_M2;
			ST_M2:    state_d = ST_M3;
			ST_M3:    state_d = ST_M4;
			ST_M4:    state_d = ST_M5;
			ST_M5:    state_d = ST_BIAS;
			ST_BIAS:  state_d = ST_WAJ;
			ST_WAJ:   state_d = ST_NEXT;
			ST_NEXT:  state_d = st.i_last ? ST_DONE : ST_ERUN;
			ST_DONE:  state_d = ST_EMIT;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.mul  = MUL_ERR;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_RD:    cmd.rd_cap = 1'b1;
			ST_EMIT:  cmd.emit = st.out_free;
			ST_PINIT: begin
				cmd.pass_init = 1'b1;
				cmd.err_start = 1'b1;
			end
			ST_ERUN:  cmd.err_issue = 1'b1;
			ST_EFIN:  cmd.err_fin = 1'b1;
			ST_KKT:   cmd.part_rd = st.viol;
			ST_JCHK: begin
				cmd.j_latch   = 1'b1;
				cmd.err_start = !st.jbad;
				cmd.sel_j     = 1'b1;
			end
			ST_ECHK:  cmd.bnd_latch = 1'b1;
			ST_LHCHK: cmd.kij_rd = 1'b1;
			ST_ETA:   cmd.eta_latch = 1'b1;
			ST_DIVGO: cmd.div_start = 1'b1;
			ST_CLIP:  cmd.clip = 1'b1;
			ST_DACHK: cmd.da_latch = 1'b1;
			ST_M1:    cmd.mul = MUL_TI_KII;
			ST_M2: begin
				cmd.mul     = MUL_TJ_KIJ;
				cmd.b1_init = 1'b1;
			end
			ST_M3: begin
				cmd.mul    = MUL_TI_KIJ;
				cmd.b1_sub = 1'b1;
			end
			ST_M4: begin
				cmd.mul     = MUL_TJ_KJJ;
				cmd.b2_init = 1'b1;
			end
			ST_M5:    cmd.b2_sub = 1'b1;
			ST_BIAS:  cmd.bias_upd = 1'b1;
			ST_WAJ:   cmd.aj_wr = 1'b1;
			ST_NEXT: begin
				cmd.i_inc     = !st.i_last;
				cmd.err_start = !st.i_last;
			end
			ST_DONE:  cmd.done_cap = 1'b1;
			default: ;
		endcase
	end

endmodule

FILE: hdl/smo_svm_trainer.sv
// Top level of the simplified SMO support vector machine trainer.
//
//  channel  dir  handshake     payload
//  req      in   valid/ready   cmd, row_index, col_index, load_value
//  rsp      out  valid/ready   result_value, result_kind
//  cfg      in   cfg_we        cfg_index, cfg_data
//
// A load is written while the controller is idle; a read passes through the RD and
// EMIT states and waits in EMIT on rsp. The length of a pass is set by the serial
// error sums (one kernel and alpha read per cycle) and the 64-step radix-2 divider
// used for each pair. One transaction is worked at a time; a finished result waits in
// the output register while the next transaction is taken.
// Alphas reset through per-entry valid bits, so no clearing pass is needed.
`timescale 1ns / 1ps
module smo_svm_trainer import smo_pkg::*; #(
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
	parameter int KERNEL_BITS = DEF_KERNEL_BITS,
	parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	smo_in_if.sink               req,
	smo_out_if.source            rsp
);

	smo_cmd_t  cmd;
	smo_stat_t st;
	logic      in_ready;

	assign req.ready = in_ready;

	smo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_cmd   (req.cmd),
		.st       (st),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	smo_dp #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.KERNEL_BITS (KERNEL_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_cmd   (req.cmd),
		.req_row   (req.row_index),
		.req_col   (req.col_index),
		.req_value (req.load_value),
		.cmd       (cmd),
		.st        (st),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.out_value (rsp.result_value),
		.out_kind  (rsp.result_kind)
	);

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the SMO trainer: loads, passes, reads and register settings.
`timescale 1ns / 1ps
module testbench;
	import smo_pkg::*;

	localparam int N_USE = 6;

	typedef struct {
		logic [RES_W-1:0]  value;
		logic [KIND_W-1:0] kind;
	} rsp_exp_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	smo_in_if  req();
	smo_out_if rsp();

	smo_svm_trainer i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.req(req), .rsp(rsp)
	);

	// trainer image kept by the testbench
	longint kmat [0:63][0:63];
	bit     neg_label [0:63];
	logic [IDX_W-1:0] partner [0:63];
	longint alpha [0:63];
	longint bias;
	longint unsigned c_box, eps, n_active;

	rsp_exp_t rsp_q[$];
	int fails, n_sent, n_runs, n_updates, n_checked;
	int hold_req, hold_left, rd_stall;
	bit no_idle;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic longint unsigned magn(longint v);
		return (v < 0) ? longint'(0) - v : v;
	endfunction

	function automatic longint sample_error(int i, int n);
		longint acc, t;
		acc = bias;
		for (int j = 0; j < n; j++) begin
			t = kmat[i][j] * alpha[j];
			acc = neg_label[j] ? acc - t : acc + t;
		end
		return neg_label[i] ? acc + (64'sd1 <<< DEF_FRAC_BITS) : acc - (64'sd1 <<< DEF_FRAC_BITS);
	endfunction

	function automatic longint smo_pass_updates();
		int n, j;
		longint cq, tol, ei, ej, ye, ai0, aj0, lo, hi, eta, stp, aj, ai, dai, daj;
		longint ti, tj, b1, b2, nb;
		longint cnt;
		bit same;
		n = (n_active > DEF_MAX_SAMPLES) ? DEF_MAX_SAMPLES : int'(n_active);
		cq = longint'(c_box) <<< DEF_FRAC_BITS;
		tol = longint'(eps);
		cnt = 0;
		for (int i = 0; i < n; i++) begin
			ei = sample_error(i, n);
			ye = neg_label[i] ? -ei : ei;
			ai0 = alpha[i];
			if (!((ye < -tol && ai0 < cq) || (ye > tol && ai0 > 0))) continue;
			j = partner[i];
			if (j >= n || j == i) continue;
			ej = sample_error(j, n);
			if (magn(ei - ej) < longint'(eps)) continue;
			aj0 = alpha[j];
			same = neg_label[i] == neg_label[j];
			if (!same) begin
				lo = (aj0 - ai0 > 0) ? aj0 - ai0 : 0;
				hi = (cq + aj0 - ai0 < cq) ? cq + aj0 - ai0 : cq;
			end else begin
				lo = (aj0 + ai0 - cq > 0) ? aj0 + ai0 - cq : 0;
				hi = (aj0 + ai0 < cq) ? aj0 + ai0 : cq;
			end
			if (magn(lo - hi) < longint'(eps)) continue;
			eta = 2 * kmat[i][j] - kmat[i][i] - kmat[j][j];
			if (eta >= 0) continue;
			stp = (ei - ej) / eta;
			aj = neg_label[j] ? aj0 + stp : aj0 - stp;
			if (aj > hi) aj = hi;
			if (aj < lo) aj = lo;
			daj = aj - aj0;
			if (magn(daj) < longint'(eps)) continue;
			ai = same ? ai0 - daj : ai0 + daj;
			dai = ai - ai0;
			ti = neg_label[i] ? -dai : dai;
			tj = neg_label[j] ? -daj : daj;
			b1 = bias - ei - ti * kmat[i][i] - tj * kmat[i][j];
			b2 = bias - ej - ti * kmat[i][j] - tj * kmat[j][j];
			if (ai > 0 && ai < cq) nb = b1;
			else if (aj > 0 && aj < cq) nb = b2;
			else nb = (b1 + b2) >>> 1;
			if (nb > BIAS_MAX) nb = BIAS_MAX;
			if (nb < BIAS_MIN) nb = BIAS_MIN;
			bias = nb;
			alpha[i] = ai;
			alpha[j] = aj;
			cnt++;
		end
		return cnt;
	endfunction

	function automatic void predict_item(logic [CMD_W-1:0] c, int r, int col, shortint v);
		rsp_exp_t e;
		case (c)
			OP_LOAD_K: kmat[r][col] = v;
			OP_LOAD_L: neg_label[r] = v < 0;
			OP_LOAD_P: partner[r] = col;
			OP_RUN: begin
				e.value = smo_pass_updates();
				e.kind = KIND_UPD;
				n_runs++;
				n_updates += int'(e.value);
				rsp_q.push_back(e);
			end
			OP_READ: begin
				if (col == 0) begin
					e.value = alpha[r];
					e.kind = KIND_ALPHA;
					rsp_q.push_back(e);
				end else if (col == 1) begin
					e.value = bias;
					e.kind = KIND_BIAS;
					rsp_q.push_back(e);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_item(logic [CMD_W-1:0] c, int r, int col, shortint v);
		int g;
		req.valid <= 1'b1;
		req.cmd <= c;
		req.row_index <= r;
		req.col_index <= col;
		req.load_value <= v;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		predict_item(c, r, col, v);
		n_sent++;
		g = pick_gap();
		if (g > 0) begin
			req.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		@(posedge clk);
		while (rsp_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, int val);
		wait_drained();
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_PENALTY: c_box = val & 16'hFFFF;
			CFG_TOL:     eps = val & 16'hFFFF;
			CFG_ACTIVE:  n_active = val & 7'h7F;
			default: ;
		endcase
	endtask

	task automatic load_kernel_entry(int r, int col);
		int v;
		v = (r == col) ? $urandom_range(256, 4000) : $urandom_range(0, 400) - 200;
		send_item(OP_LOAD_K, r, col, v);
		if (r != col) send_item(OP_LOAD_K, col, r, v);
	endtask

	task automatic test_setup_tables();
		no_idle = 1'b1;
		for (int r = 0; r < N_USE; r++)
			for (int col = r; col < N_USE; col++)
				load_kernel_entry(r, col);
		no_idle = 1'b0;
		for (int r = 0; r < N_USE; r++) begin
			send_item(OP_LOAD_L, r, $urandom_range(0, 63), $urandom_range(0, 65535));
			send_item(OP_LOAD_P, r, $urandom_range(0, N_USE - 1), $urandom_range(0, 65535));
		end
	endtask

	task automatic test_directed();
		write_reg(CFG_ACTIVE, 4);
		send_item(OP_READ, 0, 0, 0);
		send_item(OP_READ, 63, 0, -1);
		send_item(OP_READ, 0, 1, 0);
		send_item(OP_LOAD_K, 2, 3, -32768);
		send_item(OP_LOAD_K, 3, 2, 32767);
		send_item(OP_LOAD_L, 0, 0, -32768);
		send_item(OP_LOAD_L, 1, 63, 32767);
		send_item(OP_LOAD_P, 0, 1, 0);
		send_item(OP_LOAD_P, 1, 0, 0);
		send_item(OP_LOAD_P, 2, 2, 0);   // self partner
		send_item(OP_LOAD_P, 3, 63, 0);  // partner beyond n
		send_item(OP_RUN, 0, 0, 0);
		send_item(OP_LOAD_K, 2, 3, 100);
		send_item(OP_LOAD_K, 3, 2, 100);
		send_item(OP_LOAD_K, 3, 3, 0);   // eta can turn non-negative
		send_item(OP_RUN, 63, 63, -1);
		send_item(OP_READ, 0, 0, 0);
		send_item(OP_READ, 1, 1, 0);
		send_item(OP_READ, 5, 2, 0);     // bad select
		send_item(OP_READ, 5, 63, 0);
		send_item(5, 1, 1, 1);
		send_item(6, 0, 0, 0);
		send_item(7, 63, 63, -1);
		send_item(OP_RUN, 0, 0, 0);
	endtask

	task automatic random_items(int count, int n);
		int r, a, b;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			a = $urandom_range(0, n - 1);
			b = $urandom_range(0, n - 1);
			if (r < 30) send_item(OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
					$urandom_range(0, 65535));
			else if (r < 55) send_item(OP_READ, $urandom_range(0, 63), 0, $urandom_range(0, 65535));
			else if (r < 65) send_item(OP_READ, $urandom_range(0, 63), 1, 0);
			else if (r < 78) load_kernel_entry(a, b);
			else if (r < 82) send_item(OP_LOAD_K, a, b, $urandom_range(0, 65535));
			else if (r < 88) send_item(OP_LOAD_L, a, $urandom_range(0, 63), $urandom_range(0, 65535));
			else if (r < 94) send_item(OP_LOAD_P, a, $urandom_range(0, 63), 0);
			else if (r < 97) send_item(OP_READ, $urandom_range(0, 63), $urandom_range(2, 63), 0);
			else send_item($urandom_range(5, 7), $urandom_range(0, 63), $urandom_range(0, 63),
					$urandom_range(0, 65535));
		end
	endtask

	task automatic test_settings();
		write_reg(CFG_PENALTY, 1);
		write_reg(CFG_TOL, 1);
		write_reg(CFG_ACTIVE, N_USE);
		random_items(6, N_USE);
		write_reg(CFG_PENALTY, 65535);
		write_reg(CFG_TOL, 0);
		write_reg(CFG_ACTIVE, 2);
		random_items(5, 2);
		write_reg(CFG_PENALTY, 3);
		write_reg(CFG_TOL, 65535);
		write_reg(CFG_ACTIVE, N_USE);
		random_items(4, N_USE);
		write_reg(CFG_PENALTY, 10);
		write_reg(CFG_TOL, 100);
		write_reg(CFG_ACTIVE, 5);
		random_items(6, 5);
		write_reg(CFG_ACTIVE, 0);    // passes with no samples
		send_item(OP_RUN, 0, 0, 0);
		write_reg(CFG_ACTIVE, 1);
		send_item(OP_RUN, 0, 0, 0);
	endtask

	task automatic test_backpressure();
		write_reg(CFG_ACTIVE, N_USE);
		hold_req = 300;
		for (int k = 0; k < 8; k++) send_item(OP_READ, $urandom_range(0, 63), k % 2, 0);
		send_item(OP_RUN, 0, 0, 0);
		wait_drained();
		no_idle = 1'b1;
		random_items(6, N_USE);
		no_idle = 1'b0;
	endtask

	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			rsp.ready <= 1'b0;
			hold_left--;
		end else if (no_idle) begin
			rsp.ready <= 1'b1;
		end else if (rd_stall > 0) begin
			rsp.ready <= 1'b0;
			rd_stall--;
		end else begin
			case ($urandom_range(0, 99)) inside
				[0:11]:  rd_stall = $urandom_range(1, 3);
				[12:14]: rd_stall = $urandom_range(10, 40);
				default: ;
			endcase
			rsp.ready <= (rd_stall == 0);
		end
	end

	always @(posedge clk) begin
		rsp_exp_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (rsp_q.size() == 0) begin
				$error("unexpected transaction: value %0h kind %0d", rsp.result_value,
					rsp.result_kind);
				fails++;
			end else begin
				e = rsp_q.pop_front();
				n_checked++;
				if (rsp.result_value !== e.value) begin
					$error("result_value: expected %0h, got %0h", e.value, rsp.result_value);
					fails++;
				end
				if (rsp.result_kind !== e.kind) begin
					$error("result_kind: expected %0d, got %0d", e.kind, rsp.result_kind);
					fails++;
				end
			end
		end
	end

	initial begin
		#(60_000_000);
		$display("[smo_svm_trainer] ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req.valid = 1'b0;
		req.cmd = '0;
		req.row_index = '0;
		req.col_index = '0;
		req.load_value = '0;
		rsp.ready = 1'b0;
		fails = 0; n_sent = 0; n_runs = 0; n_updates = 0; n_checked = 0;
		hold_req = 0; hold_left = 0; rd_stall = 0; no_idle = 1'b0;
		for (int r = 0; r < 64; r++) begin
			alpha[r] = 0;
			neg_label[r] = 1'b0;
			partner[r] = '0;
			for (int col = 0; col < 64; col++) kmat[r][col] = 0;
		end
		bias = 0;
		c_box = 1; eps = 1; n_active = 64;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_reg(CFG_ACTIVE, N_USE);  // passes stay within the loaded samples
		test_setup_tables();
		test_directed();
		test_backpressure();
		test_settings();
		wait_drained();
		repeat (50) @(posedge clk);
		$display("%0d transactions sent, %0d results checked, %0d passes with %0d pair updates",
			n_sent, n_checked, n_runs, n_updates);
		$display("settings covered C 1..65535, tolerance 0..65535, sample count 0..6");
		if (fails == 0 && rsp_q.size() == 0)
			$display("[smo_svm_trainer] OK");
		else
			$display("[smo_svm_trainer] ERROR");
		$finish;
	end
endmodule

FILE: smo_svm_trainer.f
hdl/smo_pkg.sv
hdl/smo_in_if.sv
hdl/smo_out_if.sv
hdl/smo_div.sv
hdl/smo_dp.sv
hdl/smo_ctrl.sv
hdl/smo_svm_trainer.sv
tb/testbench.sv
